// File: rtl/rme_pkg.sv
// Shared types and constants for the modular exponentiation block.
package rme_pkg;

  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] REG_MODULUS     = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_PUBLIC_EXP  = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_PRIVATE_EXP = 2'd2;

  localparam logic FUNC_ENCRYPT = 1'b0;
  localparam logic FUNC_DECRYPT = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RED_GO,
    ST_RED_WAIT,
    ST_CHECK,
    ST_ACC_GO,
    ST_ACC_WAIT,
    ST_SQ_GO,
    ST_SQ_WAIT,
    ST_DONE
  } ctrl_state_e;

  typedef enum logic [1:0] {
    OP_REDUCE,
    OP_ACC,
    OP_SQUARE
  } mul_op_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic start_red;
    logic start_acc;
    logic start_sq;
    logic shift_exp;
    logic emit;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic mul_done;
    logic exp_zero;
    logic exp_lsb;
    logic exp_last;
    logic out_free;
  } dp_status_t;

endpackage

// File: rtl/rsa_modular_exponentiation_top.sv
// Top level of the modular exponentiation block: configuration registers and wiring.
//
// Channel   Direction  Transaction fields
// s_axis    in         tdata = message[31:0]; tuser = func (1 decrypt, 0 encrypt)
// m_axis    out        tdata = residue[31:0]
// cfg       in         write: 0 modulus, 1 public exponent, 2 private exponent
//
// One item at a time. A modular product runs bit-serially from its start state;
// an item takes a reduction, then per exponent bit a check state, a multiply
// for a set bit and a square below the highest set bit.
// The residue waits in an output register; a stalled m_axis holds the next result
// in its final state with s_axis_tready low. Reset restores the default key.
module rsa_modular_exponentiation_top #(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [31:0]                 s_axis_tdata,  // message[31:0]
  input  logic                        s_axis_tuser,  // func[0]
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [31:0]                 m_axis_tdata,  // residue[31:0]
  input  logic                        cfg_we_i,
  input  logic [rme_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [31:0]                 cfg_data_i
);
  import rme_pkg::*;

  logic [WORD_BITS-1:0] modulus_q, pub_exp_q, priv_exp_q;
  ctrl_cmd_t            cmd;
  dp_status_t           status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q  <= WORD_BITS'(32'd3233);
      pub_exp_q  <= WORD_BITS'(32'd17);
      priv_exp_q <= WORD_BITS'(32'd2753);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MODULUS:     modulus_q  <= WORD_BITS'(cfg_data_i);
        REG_PUBLIC_EXP:  pub_exp_q  <= WORD_BITS'(cfg_data_i);
        REG_PRIVATE_EXP: priv_exp_q <= WORD_BITS'(cfg_data_i);
        default: ;
      endcase
    end
  end

  rme_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  rme_datapath #(
    .WORD_BITS(WORD_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .func_i     (s_axis_tuser),
    .message_i  (s_axis_tdata),
    .modulus_i  (modulus_q),
    .pub_exp_i  (pub_exp_q),
    .priv_exp_i (priv_exp_q),
    .out_ready_i(m_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .residue_o  (m_axis_tdata)
  );

endmodule

// File: rtl/rme_modmul.sv
// Bit-serial modular multiplier: one doubling or one addition modulo m per cycle.
module rme_modmul #(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [WORD_BITS-1:0] a_i,
  input  logic [WORD_BITS-1:0] b_i,
  input  logic [WORD_BITS:0]   mod_i,
  output logic [WORD_BITS-1:0] r_o,
  output logic                 done_o
);
  localparam int unsigned CntW = $clog2(WORD_BITS);

  logic [WORD_BITS-1:0] r_q, r_d, a_q, b_q, b_d, y;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic                 phase_q, phase_d, busy_q, busy_d, done_q, done_d;
  logic [WORD_BITS:0]   sum, red;
  logic                 last;

  // One shared adder: phase 0 doubles r, phase 1 adds a when the multiplier bit is set.
  // Operands are below the modulus (or a is 1), so the sum fits one extra bit.
  always_comb begin
    y    = phase_q ? a_q : r_q;
    sum  = {1'b0, r_q} + {1'b0, y};
    red  = (sum >= mod_i) ? (sum - mod_i) : sum;
    last = (cnt_q == CntW'(WORD_BITS - 1));
  end

  always_comb begin
    r_d     = r_q;
    b_d     = b_q;
    cnt_d   = cnt_q;
    phase_d = phase_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (start_i) begin
      r_d     = '0;
      b_d     = b_i;
      cnt_d   = '0;
      phase_d = 1'b0;
      busy_d  = 1'b1;
    end else if (busy_q) begin
      if (!phase_q) begin
        r_d     = red[WORD_BITS-1:0];
        phase_d = 1'b1;
      end else begin
        if (b_q[WORD_BITS-1]) begin
          r_d = red[WORD_BITS-1:0];
        end
        b_d     = b_q << 1;
        phase_d = 1'b0;
        cnt_d   = cnt_q + CntW'(1);
        if (last) begin
          busy_d = 1'b0;
          done_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      phase_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      busy_q  <= busy_d;
      done_q  <= done_d;
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q <= r_d;
    b_q <= b_d;
    if (start_i) begin
      a_q <= a_i;
    end
  end

  assign r_o    = r_q;
  assign done_o = done_q;

endmodule

// File: rtl/rme_datapath.sv
// Datapath: operand registers, exponent shifter, multiplier and result register.
module rme_datapath #(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rme_pkg::ctrl_cmd_t   cmd_i,
  output rme_pkg::dp_status_t  status_o,
  input  logic                 func_i,
  input  logic [31:0]          message_i,
  input  logic [WORD_BITS-1:0] modulus_i,
  input  logic [WORD_BITS-1:0] pub_exp_i,
  input  logic [WORD_BITS-1:0] priv_exp_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic [31:0]          residue_o
);
  import rme_pkg::*;

  logic [WORD_BITS-1:0] msg_q, exp_q, base_q, acc_q;
  logic [WORD_BITS:0]   mod_q;
  logic [31:0]          out_data_q;
  logic                 out_valid_q;
  mul_op_e              op_q, op_d;
  logic [WORD_BITS-1:0] mul_a, mul_b, mul_r;
  logic                 mul_start, mul_done;

  always_comb begin
    mul_a = acc_q;
    mul_b = base_q;
    op_d  = op_q;
    if (cmd_i.start_red) begin
      // Reduction of the message is a product with one.
      mul_a = WORD_BITS'(1);
      mul_b = msg_q;
      op_d  = OP_REDUCE;
    end else if (cmd_i.start_acc) begin
      mul_a = acc_q;
      mul_b = base_q;
      op_d  = OP_ACC;
    end else if (cmd_i.start_sq) begin
      mul_a = base_q;
      mul_b = base_q;
      op_d  = OP_SQUARE;
    end
  end

  assign mul_start = cmd_i.start_red | cmd_i.start_acc | cmd_i.start_sq;

  rme_modmul #(
    .WORD_BITS(WORD_BITS)
  ) u_modmul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mul_start),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .mod_i  (mod_q),
    .r_o    (mul_r),
    .done_o (mul_done)
  );

  always_ff @(posedge clk_i) begin
    op_q <= op_d;
    if (cmd_i.load) begin
      msg_q <= WORD_BITS'(message_i);
      exp_q <= (func_i == FUNC_DECRYPT) ? priv_exp_i : pub_exp_i;
      acc_q <= WORD_BITS'(1);
      // A zero modulus stands for 2^WORD_BITS, so arithmetic wraps at the word width.
      mod_q <= (modulus_i == '0) ? {1'b1, {WORD_BITS{1'b0}}} : {1'b0, modulus_i};
    end else begin
      if (cmd_i.shift_exp) begin
        exp_q <= exp_q >> 1;
      end
      if (mul_done) begin
        case (op_q)
          OP_ACC:  acc_q  <= mul_r;
          default: base_q <= mul_r;
        endcase
      end
    end
    if (cmd_i.emit) begin
      out_data_q <= 32'(acc_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_comb begin
    status_o.mul_done = mul_done;
    status_o.exp_zero = (exp_q == '0);
    status_o.exp_lsb  = exp_q[0];
    status_o.exp_last = (exp_q[WORD_BITS-1:1] == '0);
    status_o.out_free = !out_valid_q || out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign residue_o   = out_data_q;

endmodule

// File: rtl/rme_ctrl.sv
// Controller state machine sequencing reduction, multiply and square steps.
module rme_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  rme_pkg::dp_status_t status_i,
  output rme_pkg::ctrl_cmd_t  cmd_o
);
  import rme_pkg::*;

  ctrl_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:     if (in_valid_i) state_d = ST_RED_GO;
      ST_RED_GO:   state_d = ST_RED_WAIT;
      ST_RED_WAIT: if (status_i.mul_done) state_d = ST_CHECK;
      ST_CHECK: begin
        if (status_i.exp_zero) begin
          state_d = ST_DONE;
        end else if (status_i.exp_lsb) begin
          state_d = ST_ACC_GO;
        end else begin
          state_d = ST_SQ_GO;
        end
      end
      ST_ACC_GO:   state_d = ST_ACC_WAIT;
      ST_ACC_WAIT: begin
        // The last set bit needs no further squaring of the base.
        if (status_i.mul_done) begin
          state_d = status_i.exp_last ? ST_DONE : ST_SQ_GO;
        end
      end
      ST_SQ_GO:    state_d = ST_SQ_WAIT;
      ST_SQ_WAIT:  if (status_i.mul_done) state_d = ST_CHECK;
      ST_DONE:     if (status_i.out_free) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_RED_GO:  cmd_o.start_red = 1'b1;
      ST_ACC_GO:  cmd_o.start_acc = 1'b1;
      ST_SQ_GO:   cmd_o.start_sq  = 1'b1;
      ST_SQ_WAIT: cmd_o.shift_exp = status_i.mul_done;
      ST_DONE:    cmd_o.emit      = status_i.out_free;
      default:    cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: bench/tb_top.sv
// Self-checking testbench for the RSA square-and-multiply exponentiation block.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rme_pkg::*;

  // Index 3 is not a register; a write to it must leave the key untouched.
  localparam logic [CfgIdxW-1:0] REG_UNUSED = 2'd3;
  localparam int unsigned LONG_HOLD = 12000;

  typedef struct {
    logic        fn;
    logic [31:0] msg;
    logic [31:0] residue;
  } residue_exp_t;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [31:0]         s_axis_tdata;   // message[31:0]
  logic                s_axis_tuser;   // func[0]
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [31:0]         m_axis_tdata;   // residue[31:0]
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [31:0]         cfg_data_i;

  // Local copy of the key registers, matching their reset values.
  logic [31:0] modulus_q  = 32'd3233;
  logic [31:0] pub_exp_q  = 32'd17;
  logic [31:0] priv_exp_q = 32'd2753;

  residue_exp_t residue_q[$];
  residue_exp_t want;
  int unsigned  err_count = 0;
  int unsigned  rx_hold = 0;
  int unsigned  rx_stall = 0;
  bit           idle_en = 1'b1;

  rsa_modular_exponentiation_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #40_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

  // Right-to-left square-and-multiply; a zero modulus stands for 2^32.
  function automatic logic [31:0] modexp_residue(logic fn, logic [31:0] msg);
    logic [31:0] e;
    logic [63:0] m;
    logic [63:0] base;
    logic [63:0] acc;
    e = (fn == FUNC_DECRYPT) ? priv_exp_q : pub_exp_q;
    if (e == 32'd0) return 32'd1;
    m = (modulus_q == 32'd0) ? 64'h1_0000_0000 : {32'd0, modulus_q};
    base = {32'd0, msg} % m;
    acc = 64'd1;
    for (int i = 0; i < 32; i++) begin
      if (e[i]) acc = (acc * base) % m;
      base = (base * base) % m;
    end
    return acc[31:0];
  endfunction

  // Mostly back-to-back, sometimes a short gap, rarely a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  function automatic logic [31:0] pick_modulus();
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return 32'd1;
      2: return 32'hFFFF_FFFF;
      3: return 32'd1 << $urandom_range(1, 31);
      4, 5: return $urandom_range(2, 65535);
      default: return $urandom;
    endcase
  endfunction

  // Short exponents keep the run fast; full-width ones appear now and then.
  function automatic logic [31:0] pick_exponent();
    logic [32:0] mask;
    case ($urandom_range(0, 11))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom;
      default: begin
        mask = (33'd1 << $urandom_range(1, 12)) - 33'd1;
        return $urandom & mask[31:0];
      end
    endcase
  endfunction

  function automatic logic [31:0] pick_message();
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return modulus_q;
      3: return modulus_q - 32'd1;
      4: return $urandom_range(0, 255);
      default: return $urandom;
    endcase
  endfunction

  task automatic report_mismatch(string what, residue_exp_t e, logic [31:0] got);
    $display("MISMATCH %s: func=%0d msg=%08h expected=%08h got=%08h",
             what, e.fn, e.msg, e.residue, got);
    err_count++;
  endtask

  // Sends one item; valid stays high only when the next item follows at once.
  task automatic send_item(logic fn, logic [31:0] msg);
    residue_exp_t e;
    int unsigned  gap;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= fn;
    s_axis_tdata  <= msg;
    do @(posedge clk_i); while (!s_axis_tready);
    e.fn = fn;
    e.msg = msg;
    e.residue = modexp_residue(fn, msg);
    residue_q.push_back(e);
    gap = idle_en ? pick_gap() : 0;
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= $urandom;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  // Drops valid and waits until every result has come back.
  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (residue_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      REG_MODULUS:     modulus_q  = val;
      REG_PUBLIC_EXP:  pub_exp_q  = val;
      REG_PRIVATE_EXP: priv_exp_q = val;
      default: ;
    endcase
  endtask

  // Textbook key n = 61 * 53 straight out of reset.
  task automatic test_reset_key();
    send_item(FUNC_ENCRYPT, 32'd65);
    send_item(FUNC_DECRYPT, 32'd2790);
    send_item(FUNC_ENCRYPT, 32'd0);
    send_item(FUNC_DECRYPT, 32'hFFFF_FFFF);
  endtask

  // A zero exponent gives 1 even with a modulus of 1.
  task automatic test_zero_exponent();
    wait_idle();
    write_reg(REG_MODULUS, 32'd1);
    write_reg(REG_PUBLIC_EXP, 32'd0);
    write_reg(REG_PRIVATE_EXP, 32'd0);
    send_item(FUNC_ENCRYPT, 32'd5);
    send_item(FUNC_DECRYPT, 32'd0);
    wait_idle();
    write_reg(REG_PUBLIC_EXP, 32'd3);
    send_item(FUNC_ENCRYPT, 32'd7);
  endtask

  // A zero modulus makes all arithmetic wrap at 32 bits.
  task automatic test_zero_modulus();
    wait_idle();
    write_reg(REG_MODULUS, 32'd0);
    write_reg(REG_PRIVATE_EXP, 32'hFFFF_FFFF);
    send_item(FUNC_ENCRYPT, 32'hFFFF_FFFF);
    send_item(FUNC_DECRYPT, 32'd3);
    send_item(FUNC_ENCRYPT, 32'h8000_0000);
  endtask

  task automatic test_full_width();
    wait_idle();
    write_reg(REG_MODULUS, 32'hFFFF_FFFF);
    write_reg(REG_PUBLIC_EXP, 32'hFFFF_FFFF);
    send_item(FUNC_ENCRYPT, 32'hFFFF_FFFF);
    send_item(FUNC_DECRYPT, 32'hFFFF_FFFE);
    send_item(FUNC_ENCRYPT, 32'd2);
    wait_idle();
    write_reg(REG_MODULUS, 32'hFFFF_FFFB);
    send_item(FUNC_DECRYPT, 32'h1234_5678);
  endtask

  task automatic test_unused_index();
    wait_idle();
    write_reg(REG_MODULUS, 32'd3233);
    write_reg(REG_PUBLIC_EXP, 32'd17);
    write_reg(REG_PRIVATE_EXP, 32'd2753);
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    send_item(FUNC_ENCRYPT, 32'd17);
    send_item(FUNC_DECRYPT, 32'd17);
  endtask

  task automatic load_random_key();
    wait_idle();
    write_reg(REG_MODULUS, pick_modulus());
    write_reg(REG_PUBLIC_EXP, pick_exponent());
    write_reg(REG_PRIVATE_EXP, pick_exponent());
  endtask

  task automatic test_random_keys();
    for (int p = 0; p < 8; p++) begin
      load_random_key();
      for (int k = 0; k < 15; k++) send_item($urandom_range(0, 1), pick_message());
    end
  endtask

  // Receiver holds off long enough for the block to fill and stall its input.
  task automatic test_output_stall();
    wait_idle();
    write_reg(REG_MODULUS, $urandom);
    write_reg(REG_PUBLIC_EXP, $urandom & 32'hFFFF);
    write_reg(REG_PRIVATE_EXP, $urandom & 32'hFFFF);
    rx_hold = LONG_HOLD;
    for (int k = 0; k < 5; k++) send_item($urandom_range(0, 1), pick_message());
  endtask

  task automatic test_streaming();
    load_random_key();
    idle_en = 1'b0;
    for (int k = 0; k < 12; k++) send_item($urandom_range(0, 1), pick_message());
    wait_idle();
    idle_en = 1'b1;
  endtask

  // Result receiver with random back-pressure.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold > 0) begin
        m_axis_tready <= 1'b0;
        rx_hold--;
      end else if (rx_stall > 0) begin
        m_axis_tready <= 1'b0;
        rx_stall--;
      end else begin
        m_axis_tready <= 1'b1;
        if (idle_en) rx_stall = pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (residue_q.size() == 0) begin
        want = '{fn: 1'b0, msg: 32'd0, residue: 32'd0};
        report_mismatch("unexpected transaction", want, m_axis_tdata);
      end else begin
        want = residue_q.pop_front();
        if (m_axis_tdata !== want.residue) report_mismatch("residue", want, m_axis_tdata);
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 32'd0;
    s_axis_tuser  = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_data_i    = 32'd0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_key();
    test_zero_exponent();
    test_zero_modulus();
    test_full_width();
    test_unused_index();
    test_random_keys();
    test_output_stall();
    test_streaming();

    wait_idle();
    repeat (100) @(posedge clk_i);
    if (err_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
